// ===== sv/pngu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Filter type codes, register map and fixed field widths shared by the
// channel interfaces and the core.
// ----------------------------------------------------------------------------
package pngu_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned BppRegW   = 3;
  localparam int unsigned RowPixW   = 12;
  localparam int unsigned RowsW     = 16;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 4;

  localparam logic [BppRegW-1:0] BppReset     = 3'd3;
  localparam logic [RowPixW-1:0] RowPixReset  = 12'd1;
  localparam logic [RowsW-1:0]   RowsReset    = 16'd1;

  typedef enum logic [1:0] {
    REG_BYTES_PER_PIXEL = 2'd0,
    REG_ROW_PIXELS      = 2'd1,
    REG_IMAGE_ROWS      = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  localparam logic [ByteW-1:0] FilterMax = 8'd4;

endpackage : pngu_pkg
`default_nettype wire

// ===== sv/pngu_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PNG unfilter input channel
// Valid/ready channel carrying one filtered stream byte per beat.
// ----------------------------------------------------------------------------
interface pngu_in_if;
  logic                            valid;
  logic                            ready;
  logic [pngu_pkg::ByteW-1:0]      filtered_byte;

  modport source (output valid, output filtered_byte, input ready);
  modport sink   (input valid, input filtered_byte, output ready);
endinterface : pngu_in_if
`default_nettype wire

// ===== sv/pngu_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PNG unfilter output channel
// Valid/ready channel carrying one reconstructed byte and its flags per beat.
// ----------------------------------------------------------------------------
interface pngu_out_if;
  logic                            valid;
  logic                            ready;
  logic [pngu_pkg::ByteW-1:0]      pixel_byte;
  logic                            last_in_row;
  logic                            last_in_image;
  logic                            bad_filter;

  modport source (output valid, output pixel_byte, output last_in_row,
                  output last_in_image, output bad_filter, input ready);
  modport sink   (input valid, input pixel_byte, input last_in_row,
                  input last_in_image, input bad_filter, output ready);
endinterface : pngu_out_if
`default_nettype wire

// ===== sv/png_scanline_unfilter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PNG scanline unfilter core
// Rebuilds the samples of a non-interlaced PNG image from its filtered byte
// stream using the None, Sub, Up, Average and Paeth rules.
//
// The input channel takes one stream byte per beat. The first byte of each
// row is the filter type and produces no output beat; every other byte
// produces one output beat with the reconstructed sample and row and image
// end flags. A filter type above four produces a single beat with
// bad_filter set, after which the rest of that image is consumed silently.
// The geometry must be programmed over the APB port while the core is idle;
// the core does not enforce this. An accepted byte and its upper-row line
// store read go into the stage register; the result enters the output
// register, which offers the beat, once that is free. One byte is taken
// every cycle unless the receiver stalls: the line store has one read and
// one write port, so the upper-row read of a byte overlaps the write of the
// one before. When the receiver stalls, the output register holds its beat
// and the next byte that produces a beat waits in the stage register; the
// input then stops. Reset clears the configuration to its defaults and the
// row counters; the line store is not cleared, as row zero ignores it.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core #(
  parameter int unsigned MAX_ROW_BYTES       = 8192,
  parameter int unsigned MAX_BYTES_PER_PIXEL = 4
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  pngu_in_if.sink                                 in_i,
  pngu_out_if.source                              out_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pngu_pkg::ApbAddrW-1:0]      paddr,
  input  wire logic [pngu_pkg::ApbDataW-1:0]      pwdata,
  output logic      [pngu_pkg::ApbDataW-1:0]      prdata,
  output logic                                    pready
);

  localparam int unsigned AW   = $clog2(MAX_ROW_BYTES);
  localparam int unsigned BW   = $clog2(MAX_BYTES_PER_PIXEL + 1);
  localparam int unsigned CW   = (BW > pngu_pkg::BppRegW) ? BW : pngu_pkg::BppRegW;
  localparam int unsigned LW   = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
  localparam int unsigned PW0  = pngu_pkg::RowPixW + BW;
  localparam int unsigned NW   = (PW0 > AW + 1) ? PW0 : AW + 1;
  localparam int unsigned RW   = pngu_pkg::RowsW;

  typedef logic [pngu_pkg::ByteW-1:0] byte_t;

  function automatic logic [9:0] abs_diff(input logic signed [10:0] v);
    logic signed [10:0] n;
    n = -v;
    return v[10] ? n[9:0] : v[9:0];
  endfunction

  // Configuration registers
  logic [pngu_pkg::BppRegW-1:0] bpp_q;
  logic [pngu_pkg::RowPixW-1:0] row_pix_q;
  logic [RW-1:0]                rows_q;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q     <= pngu_pkg::BppReset;
      row_pix_q <= pngu_pkg::RowPixReset;
      rows_q    <= pngu_pkg::RowsReset;
    end else if (cfg_wr) begin
      case (pngu_pkg::reg_idx_e'(paddr[3:2]))
        pngu_pkg::REG_BYTES_PER_PIXEL: bpp_q     <= pwdata[pngu_pkg::BppRegW-1:0];
        pngu_pkg::REG_ROW_PIXELS:      row_pix_q <= pwdata[pngu_pkg::RowPixW-1:0];
        pngu_pkg::REG_IMAGE_ROWS:      rows_q    <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (pngu_pkg::reg_idx_e'(paddr[3:2]))
      pngu_pkg::REG_BYTES_PER_PIXEL: prdata = pngu_pkg::ApbDataW'(bpp_q);
      pngu_pkg::REG_ROW_PIXELS:      prdata = pngu_pkg::ApbDataW'(row_pix_q);
      pngu_pkg::REG_IMAGE_ROWS:      prdata = pngu_pkg::ApbDataW'(rows_q);
      default:                       prdata = '0;
    endcase
  end

  // Effective geometry
  logic [CW-1:0]            bpp_ext;
  logic [BW-1:0]            bpp_eff;
  logic [pngu_pkg::RowPixW-1:0] row_pix_eff;
  logic [RW-1:0]            rows_eff;
  logic [NW-1:0]            prod;
  logic [AW:0]              nbytes;

  always_comb begin
    bpp_ext = CW'(bpp_q);
    if (bpp_ext == '0) begin
      bpp_eff = BW'(1);
    end else if (bpp_ext > CW'(MAX_BYTES_PER_PIXEL)) begin
      bpp_eff = BW'(MAX_BYTES_PER_PIXEL);
    end else begin
      bpp_eff = BW'(bpp_ext);
    end
    row_pix_eff = (row_pix_q == '0) ? pngu_pkg::RowPixW'(1) : row_pix_q;
    rows_eff    = (rows_q == '0) ? RW'(1) : rows_q;
    prod        = NW'(row_pix_eff) * NW'(bpp_eff);
    nbytes      = (prod > NW'(MAX_ROW_BYTES)) ? (AW+1)'(MAX_ROW_BYTES) : (AW+1)'(prod);
  end

  // Front control state, updated as each byte is accepted
  logic                 awaiting_q, awaiting_d;
  logic                 dropping_q, dropping_d;
  logic [AW-1:0]        byte_in_row_q, byte_in_row_d;
  logic [RW-1:0]        row_index_q, row_index_d;
  pngu_pkg::filter_e    row_filter_q, row_filter_d;

  // Stage register
  logic                 s1_valid_q;
  logic                 s1_data_q, s1_bad_q;
  byte_t                s1_byte_q;
  pngu_pkg::filter_e    s1_filter_q;
  logic                 s1_a_ok_q, s1_row_nz_q;
  logic [LW-1:0]        s1_sel_q;
  logic [AW-1:0]        s1_pos_q;
  logic                 s1_end_row_q, s1_end_img_q;

  logic                 s0_data, s0_bad;
  logic [AW-1:0]        pos;
  logic                 end_row, end_img;
  logic                 in_fire, s1_emit, s1_adv, out_free;

  assign out_free = !out_o.valid || out_o.ready;
  assign s1_emit  = s1_data_q || s1_bad_q;
  assign s1_adv   = s1_valid_q && (!s1_emit || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    awaiting_d    = awaiting_q;
    dropping_d    = dropping_q;
    byte_in_row_d = byte_in_row_q;
    row_index_d   = row_index_q;
    row_filter_d  = row_filter_q;
    s0_data       = 1'b0;
    s0_bad        = 1'b0;
    pos = ({1'b0, byte_in_row_q} >= nbytes) ? AW'(nbytes - 1'b1) : byte_in_row_q;
    end_row = ((AW+1)'(byte_in_row_q) + 1'b1) >= nbytes;
    end_img = end_row && (({1'b0, row_index_q} + 1'b1) >= {1'b0, rows_eff});
    if (awaiting_q) begin
      awaiting_d    = 1'b0;
      byte_in_row_d = '0;
      if (!dropping_q) begin
        if (in_i.filtered_byte > pngu_pkg::FilterMax) begin
          dropping_d = 1'b1;
          s0_bad     = 1'b1;
        end else begin
          row_filter_d = pngu_pkg::filter_e'(in_i.filtered_byte[2:0]);
        end
      end
    end else begin
      s0_data = !dropping_q;
      if (end_row) begin
        byte_in_row_d = '0;
        awaiting_d    = 1'b1;
        if (end_img) begin
          row_index_d = '0;
          dropping_d  = 1'b0;
        end else begin
          row_index_d = row_index_q + 1'b1;
        end
      end else begin
        byte_in_row_d = pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q    <= 1'b1;
      dropping_q    <= 1'b0;
      byte_in_row_q <= '0;
      row_index_q   <= '0;
      row_filter_q  <= pngu_pkg::FILT_NONE;
      s1_valid_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        awaiting_q    <= awaiting_d;
        dropping_q    <= dropping_d;
        byte_in_row_q <= byte_in_row_d;
        row_index_q   <= row_index_d;
        row_filter_q  <= row_filter_d;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q    <= s0_data;
      s1_bad_q     <= s0_bad;
      s1_byte_q    <= in_i.filtered_byte;
      s1_filter_q  <= row_filter_q;
      s1_a_ok_q    <= (AW+1)'(pos) >= (AW+1)'(bpp_eff);
      s1_row_nz_q  <= row_index_q != '0;
      s1_sel_q     <= LW'(bpp_eff - 1'b1);
      s1_pos_q     <= pos;
      s1_end_row_q <= end_row;
      s1_end_img_q <= end_img;
    end
  end

  // Line store holding the previous reconstructed row
  byte_t  line_q [MAX_ROW_BYTES];
  byte_t  upper_q;
  logic   wr_en;
  byte_t  x;

  assign wr_en = s1_adv && s1_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_q[s1_pos_q] <= x;
    end
    if (in_fire) begin
      upper_q <= line_q[pos];
    end
  end

  // Reconstruction
  byte_t  left_q   [MAX_BYTES_PER_PIXEL];
  byte_t  upleft_q [MAX_BYTES_PER_PIXEL];
  byte_t  a, b, c, pred;
  logic [8:0]          sum_ab;
  logic signed [10:0]  p;
  logic [9:0]          pa, pb, pc;

  always_comb begin
    a = s1_a_ok_q ? left_q[s1_sel_q] : '0;
    b = s1_row_nz_q ? upper_q : '0;
    c = (s1_a_ok_q && s1_row_nz_q) ? upleft_q[s1_sel_q] : '0;
    sum_ab = {1'b0, a} + {1'b0, b};
    p  = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({3'b000, c});
    pa = abs_diff(p - $signed({3'b000, a}));
    pb = abs_diff(p - $signed({3'b000, b}));
    pc = abs_diff(p - $signed({3'b000, c}));
    case (s1_filter_q)
      pngu_pkg::FILT_SUB: pred = a;
      pngu_pkg::FILT_UP:  pred = b;
      pngu_pkg::FILT_AVG: pred = sum_ab[8:1];
      pngu_pkg::FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default: pred = '0;
    endcase
    x = s1_byte_q + pred;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      for (int k = MAX_BYTES_PER_PIXEL - 1; k > 0; k--) begin
        left_q[k]   <= left_q[k-1];
        upleft_q[k] <= upleft_q[k-1];
      end
      left_q[0]   <= x;
      upleft_q[0] <= b;
    end
  end

  // Output register
  logic out_valid_q;
  byte_t out_byte_q;
  logic out_last_row_q, out_last_img_q, out_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit) begin
      out_byte_q     <= s1_bad_q ? '0 : x;
      out_last_row_q <= s1_data_q && s1_end_row_q;
      out_last_img_q <= s1_data_q && s1_end_img_q;
      out_bad_q      <= s1_bad_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_byte    = out_byte_q;
  assign out_o.last_in_row   = out_last_row_q;
  assign out_o.last_in_image = out_last_img_q;
  assign out_o.bad_filter    = out_bad_q;

endmodule : png_scanline_unfilter_core
`default_nettype wire
